// File: hw/rtl/ffha_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ffha_pkg
// Shared types and constants of the first-fit heap allocator.
// ============================================================================
package ffha_pkg;

   // Default sizing handed to the top level
   localparam int HEAP_WORDS_DEF = 1024;
   localparam int WORD_BYTES_DEF = 4;

   // The pool never exceeds this many words (length headers are 12-bit signed)
   localparam int POOL_CAP = 2047;
   localparam int POOL_W   = 11;

   // Heap words: signed lengths, header included
   localparam int WORD_W = 12;
   // Walk positions and lengths, unsigned
   localparam int POS_W  = 12;

   // Field widths of one beat
   localparam int TYPE_W   = 2;
   localparam int BYTES_W  = 13;
   localparam int HANDLE_W = 10;
   localparam int STATUS_W = 2;

   // Ceil/floor division by the word size through a reciprocal multiply:
   // operand up to BYTES_W + 1 bits, shift = operand width + 3 covers divisors to 8
   localparam int OPND_W    = BYTES_W + 1;
   localparam int DIV_SHIFT = OPND_W + 3;
   localparam int RECIP_W   = DIV_SHIFT + 1;
   localparam int PROD_W    = OPND_W + RECIP_W;
   localparam int QUOT_W    = PROD_W - DIV_SHIFT;

   typedef enum logic [TYPE_W-1:0] {
      REQ_INIT  = 2'd0,
      REQ_ALLOC = 2'd1,
      REQ_FREE  = 2'd2
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_NO_FIT   = 2'd1,
      ST_TOO_BIG  = 2'd2,
      ST_FREE_IGN = 2'd3
   } status_code_type;

   typedef enum logic [0:0] {
      RD_POS = 1'b0,
      RD_NXT = 1'b1
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_POOL  = 3'd0,
      WR_FIRST = 3'd1,
      WR_STUB  = 3'd2,
      WR_SPLIT = 3'd3,
      WR_MARK  = 3'd4,
      WR_MERGE = 3'd5
   } wr_sel_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV,
      S_DISPATCH,
      S_INIT_POOL,
      S_INIT_FIRST,
      S_INIT_STUB,
      S_A_RD,
      S_A_EVAL,
      S_A_SPLIT,
      S_A_MARK,
      S_F_RD,
      S_F_EVAL,
      S_M_RD,
      S_M_EVAL,
      S_M_WR,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic            load_req;
      logic            mul;
      logic            set_pool;
      logic            pos_init;
      logic            pos_step;
      logic            len_from_hdr;
      logic            len_add;
      logic            rd_en;
      rd_sel_type      rd_sel;
      logic            wr_en;
      wr_sel_type      wr_sel;
      logic            res_load;
      logic            res_granted;
      logic            res_use_pos;
      status_code_type res_status;
      logic            load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [TYPE_W-1:0] req_kind;
      logic              need_gt_pool;
      logic              pool_small;
      logic              handle_bad;
      logic              pos_at_end;
      logic              rd_zero;
      logic              rd_fits;
      logic              rd_neg;
      logic              step_over;
      logic              pos_is_h;
      logic              nxt_at_end;
      logic              merge_stop;
      logic              rsp_busy;
   } ctrl_stat_type;

endpackage

// File: hw/rtl/ffha_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// ffha_datapath
// Heap word store, walk registers, word-size divider and result register.
// ============================================================================
module ffha_datapath #(
   parameter int HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF,
   parameter int WORD_BYTES = ffha_pkg::WORD_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ffha_pkg::ctrl_cmd_type          cmd,
   output ffha_pkg::ctrl_stat_type         stat,
   input  logic [ffha_pkg::TYPE_W-1:0]     in_type,
   input  logic [ffha_pkg::BYTES_W-1:0]    in_bytes,
   input  logic [ffha_pkg::HANDLE_W-1:0]   in_handle,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic                            rsp_granted,
   output logic [ffha_pkg::HANDLE_W-1:0]   rsp_handle,
   output logic [ffha_pkg::STATUS_W-1:0]   rsp_status
);

   localparam int MEM_DEPTH = (HEAP_WORDS < ffha_pkg::POOL_CAP) ?
                              HEAP_WORDS : ffha_pkg::POOL_CAP;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);
   localparam int POS_W     = ffha_pkg::POS_W;
   localparam int WORD_W    = ffha_pkg::WORD_W;
   localparam int POOL_W    = ffha_pkg::POOL_W;
   localparam int QUOT_W    = ffha_pkg::QUOT_W;
   localparam int RECIP_W   = ffha_pkg::RECIP_W;
   localparam int OPND_W    = ffha_pkg::OPND_W;
   localparam int PROD_W    = ffha_pkg::PROD_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((1 << ffha_pkg::DIV_SHIFT) + WORD_BYTES - 1) / WORD_BYTES);

   // Request registers
   logic [ffha_pkg::TYPE_W-1:0]   type_ff;
   logic [ffha_pkg::HANDLE_W-1:0] handle_ff;
   logic [PROD_W-1:0]             prod_ff;
   logic [POOL_W-1:0]             pool_ff, pool_in;
   logic [POS_W-1:0]              pos_ff, pos_in;
   logic [POS_W-1:0]              len_ff, len_in;
   logic [WORD_W-1:0]             rd_ff;

   // Result staging and output register
   logic                          res_granted_ff;
   logic [ffha_pkg::HANDLE_W-1:0] res_handle_ff;
   logic [ffha_pkg::STATUS_W-1:0] res_status_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_granted_ff;
   logic [ffha_pkg::HANDLE_W-1:0] rsp_handle_ff;
   logic [ffha_pkg::STATUS_W-1:0] rsp_status_ff;

   logic [WORD_W-1:0] heap_mem [MEM_DEPTH];

   logic [OPND_W-1:0] opnd;
   logic [QUOT_W-1:0] quot;
   logic [POS_W-1:0]  total;
   logic [POOL_W-1:0] pool_new;
   logic [POS_W-1:0]  pend;
   logic [POS_W-1:0]  rd_abs;
   logic              rd_pos;
   logic [POS_W:0]    pos_sum;
   logic [POS_W:0]    nxt;
   logic [POS_W+1:0]  nxt_sum;
   logic [POS_W:0]    wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [MEM_AW-1:0] rd_addr;

   // Round up for an allocation, down for a pool size
   assign opnd = (in_type == ffha_pkg::REQ_ALLOC) ?
                 OPND_W'(in_bytes) + OPND_W'(WORD_BYTES - 1) : OPND_W'(in_bytes);
   assign quot     = prod_ff[PROD_W-1:ffha_pkg::DIV_SHIFT];
   assign total    = quot[POS_W-1:0] + POS_W'(1);
   assign pool_new = (quot > QUOT_W'(MEM_DEPTH)) ? POOL_W'(MEM_DEPTH) : quot[POOL_W-1:0];
   assign pend     = POS_W'(pool_ff) - POS_W'(1);
   assign rd_abs   = rd_ff[WORD_W-1] ? POS_W'(-rd_ff) : POS_W'(rd_ff);
   assign rd_pos   = !rd_ff[WORD_W-1] && (rd_ff != '0);
   assign pos_sum  = {1'b0, pos_ff} + {1'b0, rd_abs};
   assign nxt      = {1'b0, pos_ff} + {1'b0, len_ff};
   assign nxt_sum  = {1'b0, nxt} + (POS_W + 2)'(rd_ff);

   always_comb begin
      stat.req_kind     = type_ff;
      stat.need_gt_pool = quot > QUOT_W'(pool_ff);
      stat.pool_small   = pool_ff < POOL_W'(3);
      stat.handle_bad   = (pool_ff < POOL_W'(3)) || (handle_ff == '0) ||
                          (POS_W'(handle_ff) >= pend);
      stat.pos_at_end   = pos_ff >= pend;
      stat.rd_zero      = rd_ff == '0;
      stat.rd_fits      = rd_pos && (POS_W'(rd_ff) > total);
      stat.rd_neg       = rd_ff[WORD_W-1];
      stat.step_over    = pos_sum > {1'b0, pend};
      stat.pos_is_h     = pos_ff == POS_W'(handle_ff);
      stat.nxt_at_end   = nxt >= {1'b0, pend};
      stat.merge_stop   = !rd_pos || (nxt_sum > (POS_W + 2)'(pend));
      stat.rsp_busy     = rsp_valid_ff && !rsp_ready;
   end

   // Write port address and data
   always_comb begin
      wr_addr = '0;
      wr_data = '0;
      unique case (cmd.wr_sel)
         ffha_pkg::WR_POOL: begin
            wr_addr = '0;
            wr_data = WORD_W'(pool_new);
         end
         ffha_pkg::WR_FIRST: begin
            wr_addr = (POS_W + 1)'(1);
            wr_data = WORD_W'(pool_ff) - WORD_W'(2);
         end
         ffha_pkg::WR_STUB: begin
            wr_addr = {1'b0, pend};
            wr_data = '0;
         end
         ffha_pkg::WR_SPLIT: begin
            wr_addr = {1'b0, pos_ff} + {1'b0, total};
            wr_data = rd_ff - WORD_W'(total);
         end
         ffha_pkg::WR_MARK: begin
            wr_addr = {1'b0, pos_ff};
            wr_data = -WORD_W'(total);
         end
         ffha_pkg::WR_MERGE: begin
            wr_addr = {1'b0, pos_ff};
            wr_data = WORD_W'(len_ff);
         end
         default: begin
            wr_addr = '0;
            wr_data = '0;
         end
      endcase
   end

   assign rd_addr = (cmd.rd_sel == ffha_pkg::RD_NXT) ? nxt[MEM_AW-1:0] : pos_ff[MEM_AW-1:0];

   // Heap word store: one write, one registered read
   always_ff @(posedge clock) begin
      if (cmd.wr_en && (wr_addr < (POS_W + 1)'(MEM_DEPTH))) begin
         heap_mem[wr_addr[MEM_AW-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_ff <= heap_mem[rd_addr];
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (cmd.pos_init) begin
         pos_in = POS_W'(1);
      end else if (cmd.pos_step) begin
         pos_in = pos_sum[POS_W-1:0];
      end
      len_in = len_ff;
      if (cmd.len_from_hdr) begin
         len_in = POS_W'(-rd_ff);
      end else if (cmd.len_add) begin
         len_in = len_ff + POS_W'(rd_ff);
      end
      pool_in = cmd.set_pool ? pool_new : pool_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         type_ff   <= in_type;
         handle_ff <= in_handle;
      end
      if (cmd.mul) begin
         prod_ff <= PROD_W'(opnd) * PROD_W'(RECIP);
      end
      pos_ff <= pos_in;
      len_ff <= len_in;
      if (cmd.res_load) begin
         res_granted_ff <= cmd.res_granted;
         res_handle_ff  <= cmd.res_use_pos ? pos_ff[ffha_pkg::HANDLE_W-1:0] : '0;
         res_status_ff  <= cmd.res_status;
      end
      if (cmd.load_rsp) begin
         rsp_granted_ff <= res_granted_ff;
         rsp_handle_ff  <= res_handle_ff;
         rsp_status_ff  <= res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pool_ff <= pool_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_granted = rsp_granted_ff;
   assign rsp_handle  = rsp_handle_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

// File: hw/rtl/ffha_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// ffha_ctrl
// Sequencer for pool init, first-fit walk, free search and forward merge.
// ============================================================================
module ffha_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ffha_pkg::ctrl_stat_type stat,
   output ffha_pkg::ctrl_cmd_type  cmd
);

   ffha_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffha_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd            = '0;
      cmd.rd_sel     = ffha_pkg::RD_POS;
      cmd.wr_sel     = ffha_pkg::WR_POOL;
      cmd.res_status = ffha_pkg::ST_OK;
      req_ready      = 1'b0;
      state_in       = state_ff;
      unique case (state_ff)
         ffha_pkg::S_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load_req = 1'b1;
               cmd.mul      = 1'b1;
               state_in     = ffha_pkg::S_DIV;
            end
         end
         ffha_pkg::S_DIV: begin
            state_in = ffha_pkg::S_DISPATCH;
         end
         ffha_pkg::S_DISPATCH: begin
            cmd.res_load = 1'b1;
            if (stat.req_kind == ffha_pkg::REQ_INIT) begin
               cmd.res_load = 1'b0;
               state_in     = ffha_pkg::S_INIT_POOL;
            end else if (stat.req_kind == ffha_pkg::REQ_ALLOC) begin
               if (stat.need_gt_pool) begin
                  cmd.res_status = ffha_pkg::ST_TOO_BIG;
                  state_in       = ffha_pkg::S_FINISH;
               end else if (stat.pool_small) begin
                  cmd.res_status = ffha_pkg::ST_NO_FIT;
                  state_in       = ffha_pkg::S_FINISH;
               end else begin
                  cmd.res_load = 1'b0;
                  cmd.pos_init = 1'b1;
                  state_in     = ffha_pkg::S_A_RD;
               end
            end else if (stat.req_kind == ffha_pkg::REQ_FREE) begin
               if (stat.handle_bad) begin
                  cmd.res_status = ffha_pkg::ST_FREE_IGN;
                  state_in       = ffha_pkg::S_FINISH;
               end else begin
                  cmd.res_load = 1'b0;
                  cmd.pos_init = 1'b1;
                  state_in     = ffha_pkg::S_F_RD;
               end
            end else begin
               cmd.res_status = ffha_pkg::ST_FREE_IGN;
               state_in       = ffha_pkg::S_FINISH;
            end
         end
         ffha_pkg::S_INIT_POOL: begin
            cmd.set_pool = 1'b1;
            cmd.wr_en    = 1'b1;
            cmd.wr_sel   = ffha_pkg::WR_POOL;
            state_in     = ffha_pkg::S_INIT_FIRST;
         end
         ffha_pkg::S_INIT_FIRST: begin
            if (stat.pool_small) begin
               cmd.res_load    = 1'b1;
               cmd.res_granted = 1'b1;
               state_in        = ffha_pkg::S_FINISH;
            end else begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = ffha_pkg::WR_FIRST;
               state_in   = ffha_pkg::S_INIT_STUB;
            end
         end
         ffha_pkg::S_INIT_STUB: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_sel      = ffha_pkg::WR_STUB;
            cmd.res_load    = 1'b1;
            cmd.res_granted = 1'b1;
            state_in        = ffha_pkg::S_FINISH;
         end
         ffha_pkg::S_A_RD: begin
            if (stat.pos_at_end) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ffha_pkg::ST_NO_FIT;
               state_in       = ffha_pkg::S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ffha_pkg::RD_POS;
               state_in   = ffha_pkg::S_A_EVAL;
            end
         end
         ffha_pkg::S_A_EVAL: begin
            if (stat.rd_zero) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ffha_pkg::ST_NO_FIT;
               state_in       = ffha_pkg::S_FINISH;
            end else if (stat.rd_fits) begin
               state_in = ffha_pkg::S_A_SPLIT;
            end else if (stat.step_over) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ffha_pkg::ST_NO_FIT;
               state_in       = ffha_pkg::S_FINISH;
            end else begin
               cmd.pos_step = 1'b1;
               state_in     = ffha_pkg::S_A_RD;
            end
         end
         ffha_pkg::S_A_SPLIT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = ffha_pkg::WR_SPLIT;
            state_in   = ffha_pkg::S_A_MARK;
         end
         ffha_pkg::S_A_MARK: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_sel      = ffha_pkg::WR_MARK;
            cmd.res_load    = 1'b1;
            cmd.res_granted = 1'b1;
            cmd.res_use_pos = 1'b1;
            state_in        = ffha_pkg::S_FINISH;
         end
         ffha_pkg::S_F_RD: begin
            if (stat.pos_at_end) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ffha_pkg::ST_FREE_IGN;
               state_in       = ffha_pkg::S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ffha_pkg::RD_POS;
               state_in   = ffha_pkg::S_F_EVAL;
            end
         end
         ffha_pkg::S_F_EVAL: begin
            if (stat.pos_is_h) begin
               if (stat.rd_neg) begin
                  cmd.len_from_hdr = 1'b1;
                  state_in         = ffha_pkg::S_M_RD;
               end else begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = ffha_pkg::ST_FREE_IGN;
                  state_in       = ffha_pkg::S_FINISH;
               end
            end else if (stat.rd_zero || stat.step_over) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ffha_pkg::ST_FREE_IGN;
               state_in       = ffha_pkg::S_FINISH;
            end else begin
               cmd.pos_step = 1'b1;
               state_in     = ffha_pkg::S_F_RD;
            end
         end
         ffha_pkg::S_M_RD: begin
            if (stat.nxt_at_end) begin
               state_in = ffha_pkg::S_M_WR;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ffha_pkg::RD_NXT;
               state_in   = ffha_pkg::S_M_EVAL;
            end
         end
         ffha_pkg::S_M_EVAL: begin
            if (stat.merge_stop) begin
               state_in = ffha_pkg::S_M_WR;
            end else begin
               cmd.len_add = 1'b1;
               state_in    = ffha_pkg::S_M_RD;
            end
         end
         ffha_pkg::S_M_WR: begin
            cmd.wr_en       = 1'b1;
            cmd.wr_sel      = ffha_pkg::WR_MERGE;
            cmd.res_load    = 1'b1;
            cmd.res_granted = 1'b1;
            state_in        = ffha_pkg::S_FINISH;
         end
         ffha_pkg::S_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = ffha_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ffha_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// File: hw/rtl/first_fit_heap_allocator_top.sv
`timescale 1ns / 1ps
// ============================================================================
// first_fit_heap_allocator_top
// First-fit boundary-tag heap allocator over an on-chip word store.
// ============================================================================
// Usage:
//   Request channel (req_*): one beat per command. tuser carries the kind
//   (init pool, allocate, free); tdata carries the byte count and the handle.
//   Response channel (rsp_*): exactly one beat per request, in order, with
//   granted, the header word address of a new block, and a status code.
// Sequence (accept, divide, dispatch, then per kind):
//   init        pool size, then first header and end stub unless under three words
//   allocate    one header read per block up to the hit, then split and mark writes
//               (early fails, too big or a pool under three words, answer from dispatch)
//   free        one header read per block walked to the handle and per neighbor
//               read for the merge, then the merged header write
//   A new request is taken in the cycle after the response is loaded. Headers are
//   read one at a time through the single read port (address, then registered data).
// Reset: clears the sequencer, the response valid and the pool size (no pool,
//   so allocations of one byte or more answer "larger than pool" until an
//   init). Heap contents are left as they are; only headers written since the
//   last init are read.
// Backpressure: the response sits in an output register; while the receiver
//   stalls, the next request is still taken and worked on, and holds in its
//   last state only until the output register frees up.
// ============================================================================
module first_fit_heap_allocator_top #(
   parameter int HEAP_WORDS = ffha_pkg::HEAP_WORDS_DEF,
   parameter int WORD_BYTES = ffha_pkg::WORD_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // [12:0] request_bytes, [22:13] block_handle, [23] zero
   input  logic [1:0]  req_tuser,  // [1:0] req_type
   // Response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata   // [0] granted, [10:1] result_handle, [12:11] status
);

   ffha_pkg::ctrl_cmd_type  cmd;
   ffha_pkg::ctrl_stat_type stat;

   logic                            rsp_granted;
   logic [ffha_pkg::HANDLE_W-1:0]   rsp_handle;
   logic [ffha_pkg::STATUS_W-1:0]   rsp_status;

   // Sequencer: one request at a time, walks headers through the datapath
   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Heap store, divider, walk registers and response register
   ffha_datapath #(
      .HEAP_WORDS (HEAP_WORDS),
      .WORD_BYTES (WORD_BYTES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .in_type     (req_tuser),
      .in_bytes    (req_tdata[12:0]),
      .in_handle   (req_tdata[22:13]),
      .rsp_ready   (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_granted (rsp_granted),
      .rsp_handle  (rsp_handle),
      .rsp_status  (rsp_status)
   );

   // Pack the response beat, pad to whole bytes
   assign rsp_tdata = {3'b000, rsp_status, rsp_handle, rsp_granted};

endmodule

// File: test/first_fit_heap_allocator_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// first_fit_heap_allocator_top_tb
// Self-checking bench for the first-fit boundary-tag heap allocator.
// ============================================================================
// A predictor in this file keeps its own copy of the heap headers and the
// pool size. Each accepted request is run through it and the reply it
// foresees is queued. A reply checker pops the oldest entry for each reply
// beat and compares granted, handle and status. Directed tasks cover the
// corner rules of the allocator; random sessions then carve pools of random
// size and mix allocations, frees of live blocks and junk requests, with
// random idle cycles on both channels.
// ============================================================================
module first_fit_heap_allocator_top_tb;

   localparam int HEAP_WORDS   = ffha_pkg::HEAP_WORDS_DEF;
   localparam int WORD_BYTES   = ffha_pkg::WORD_BYTES_DEF;
   localparam int CLK_HALF     = 10;
   localparam int RESET_CYCLES = 8;
   // A walk over a pool of 1024 one-word blocks reads one header at a time,
   // so a quiet stretch this long can only mean a hang
   localparam int QUIET_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 64;
   localparam int WORK_ITEMS   = 1200;
   // Request kind with no meaning to the allocator
   localparam logic [ffha_pkg::TYPE_W-1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic                          granted;
      logic [ffha_pkg::HANDLE_W-1:0] handle;
      ffha_pkg::status_code_type     status;
   } heap_reply_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;  // [12:0] request_bytes, [22:13] block_handle, [23] zero
   logic [1:0]  req_tuser  = '0;  // [1:0] req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [0] granted, [10:1] result_handle, [12:11] status

   // Predictor state: header words and the pool size in words
   logic signed [ffha_pkg::WORD_W-1:0] heap_words [HEAP_WORDS] = '{default: '0};
   logic [ffha_pkg::POOL_W-1:0]        pool_words = '0;

   heap_reply_type expected_replies [$];
   int             live_blocks [$];

   bit req_pace = 1'b1;
   bit rsp_pace = 1'b1;

   int error_count   = 0;
   int beats_sent    = 0;
   int replies_seen  = 0;
   int pools_carved  = 0;
   int allocs_done   = 0;
   int frees_done    = 0;
   int refusals      = 0;
   int quiet_cycles  = 0;
   int rsp_stall     = 0;

   first_fit_heap_allocator_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Out-of-range addresses read as the end stub and drop writes
   function automatic int heap_rd(int addr);
      return (addr < HEAP_WORDS) ? int'(heap_words[addr]) : 0;
   endfunction

   function automatic void heap_wr(int addr, int value);
      if (addr < HEAP_WORDS)
         heap_words[addr] = ffha_pkg::WORD_W'(value);
   endfunction

   function automatic void carve_pool(int nbytes);
      int p;
      p = nbytes / WORD_BYTES;
      if (p > HEAP_WORDS)
         p = HEAP_WORDS;
      if (p > ffha_pkg::POOL_CAP)
         p = ffha_pkg::POOL_CAP;
      pool_words = ffha_pkg::POOL_W'(p);
      heap_wr(0, p);
      // A pool under three words has no room for a block and a stub
      if (p >= 3) begin
         heap_wr(1, p - 2);
         heap_wr(p - 1, 0);
      end
      live_blocks.delete();
   endfunction

   function automatic heap_reply_type first_fit(int nbytes);
      heap_reply_type reply;
      int p, need, total, pos, len, step;
      p      = int'(pool_words);
      need   = (nbytes + WORD_BYTES - 1) / WORD_BYTES;
      reply  = '{granted: 1'b0, handle: '0, status: ffha_pkg::ST_NO_FIT};
      if (need > p) begin
         reply.status = ffha_pkg::ST_TOO_BIG;
         return reply;
      end
      if (p < 3)
         return reply;
      total = need + 1;
      pos   = 1;
      while (pos < p - 1) begin
         len = heap_rd(pos);
         if (len == 0)
            break;
         // Strictly longer only: an exact fit is passed over
         if (len > total) begin
            heap_wr(pos + total, len - total);
            heap_wr(pos, -total);
            reply = '{granted: 1'b1, handle: ffha_pkg::HANDLE_W'(pos),
                      status: ffha_pkg::ST_OK};
            return reply;
         end
         step = (len > 0) ? len : -len;
         if (pos + step > p - 1)
            break;
         pos += step;
      end
      return reply;
   endfunction

   function automatic bit release_block(int target);
      int p, pos, len, step, nxt, v;
      p   = int'(pool_words);
      pos = 1;
      if (p < 3 || target == 0 || target >= p - 1)
         return 1'b0;
      while (pos < p - 1 && pos != target) begin
         len = heap_rd(pos);
         if (len == 0)
            return 1'b0;
         step = (len > 0) ? len : -len;
         if (pos + step > p - 1)
            return 1'b0;
         pos += step;
      end
      if (pos != target || heap_rd(pos) >= 0)
         return 1'b0;
      // Swallow every free block that directly follows
      len = -heap_rd(pos);
      forever begin
         nxt = pos + len;
         if (nxt >= p - 1)
            break;
         v = heap_rd(nxt);
         if (v <= 0 || nxt + v > p - 1)
            break;
         len += v;
      end
      heap_wr(pos, len);
      return 1'b1;
   endfunction

   function automatic heap_reply_type heap_predict(logic [ffha_pkg::TYPE_W-1:0] kind,
                                                   int nbytes, int target);
      heap_reply_type reply;
      int idx [$];
      reply = '{granted: 1'b0, handle: '0, status: ffha_pkg::ST_FREE_IGN};
      case (kind)
         ffha_pkg::REQ_INIT: begin
            carve_pool(nbytes);
            pools_carved++;
            reply = '{granted: 1'b1, handle: '0, status: ffha_pkg::ST_OK};
         end
         ffha_pkg::REQ_ALLOC: begin
            reply = first_fit(nbytes);
            if (reply.granted) begin
               live_blocks.push_back(int'(reply.handle));
               allocs_done++;
            end
         end
         ffha_pkg::REQ_FREE: begin
            if (release_block(target)) begin
               idx = live_blocks.find_first_index(h) with (h == target);
               if (idx.size() != 0)
                  live_blocks.delete(idx[0]);
               frees_done++;
               reply = '{granted: 1'b1, handle: '0, status: ffha_pkg::ST_OK};
            end
         end
         default: ;
      endcase
      if (!reply.granted)
         refusals++;
      return reply;
   endfunction

   // ---------------------------------------------------------------------
   // Request side: one beat per call, entered and left at a rising edge
   // ---------------------------------------------------------------------
   task automatic send_request(logic [ffha_pkg::TYPE_W-1:0] kind, int nbytes, int target);
      int gap;
      gap = req_pace ? $urandom_range(10, 0) : 0;
      // Drop valid only when a real gap follows, so back-to-back beats stay high
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, ffha_pkg::HANDLE_W'(target), ffha_pkg::BYTES_W'(nbytes)};
      do
         @(posedge clock);
      while (!req_tready);
      expected_replies.push_back(heap_predict(kind, nbytes, target));
      beats_sent++;
   endtask

   // ---------------------------------------------------------------------
   // Reply side: check each beat against the oldest prediction, then draw
   // how long to hold ready low before the next one
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : reply_check
      heap_reply_type want;
      heap_reply_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{granted: rsp_tdata[0], handle: rsp_tdata[10:1],
                    status: ffha_pkg::status_code_type'(rsp_tdata[12:11])};
            replies_seen++;
            if (expected_replies.size() == 0) begin
               $display("%0t: reply beat with nothing pending: granted %0d handle %0d status %0d",
                        $time, got.granted, got.handle, got.status);
               error_count++;
            end else begin
               want = expected_replies.pop_front();
               if (got.granted !== want.granted) begin
                  $display("%0t: granted mismatch: expected %0d, actual %0d",
                           $time, want.granted, got.granted);
                  error_count++;
               end
               if (got.handle !== want.handle) begin
                  $display("%0t: result_handle mismatch: expected %0d, actual %0d",
                           $time, want.handle, got.handle);
                  error_count++;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, got.status);
                  error_count++;
               end
            end
            rsp_stall = rsp_pace ? $urandom_range(10, 0) : 0;
         end
         if (rsp_stall > 0) begin
            rsp_tready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: any accepted beat on either channel resets the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles, %0d replies outstanding",
                  $time, QUIET_LIMIT, expected_replies.size());
         $display("first_fit_heap_allocator_top_tb: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Right after reset there is no pool: allocate is too big, free is ignored
   task automatic test_before_init();
      send_request(ffha_pkg::REQ_ALLOC, 4, 0);
      send_request(ffha_pkg::REQ_FREE, 0, 1);
      // Unknown request kind with every byte-count and handle bit set
      send_request(REQ_UNUSED, 8191, 1023);
   endtask

   // Two-word pool: nothing fits, large requests exceed the pool
   task automatic test_tiny_pool();
      send_request(ffha_pkg::REQ_INIT, 8, 0);
      send_request(ffha_pkg::REQ_ALLOC, 0, 0);
      send_request(ffha_pkg::REQ_ALLOC, 12, 0);
   endtask

   // Ten-word pool, first block eight words long
   task automatic test_fit_rules();
      send_request(ffha_pkg::REQ_INIT, 40, 0);
      send_request(ffha_pkg::REQ_ALLOC, 28, 0);  // exact fit, refused
      send_request(ffha_pkg::REQ_ALLOC, 24, 0);  // split, one word left over
      send_request(ffha_pkg::REQ_ALLOC, 0, 0);   // header-only block vs one-word leftover
      send_request(ffha_pkg::REQ_FREE, 0, 5);    // data word
      send_request(ffha_pkg::REQ_FREE, 0, 9);    // stub
      send_request(ffha_pkg::REQ_FREE, 0, 0);    // pool size word
      send_request(ffha_pkg::REQ_FREE, 0, 1);    // merge with the leftover
      send_request(ffha_pkg::REQ_FREE, 0, 1);    // already free
      send_request(ffha_pkg::REQ_ALLOC, 0, 0);   // header-only block
      send_request(ffha_pkg::REQ_ALLOC, 1, 0);   // walks past a used block
      send_request(ffha_pkg::REQ_FREE, 0, 2);    // merges the tail
      send_request(ffha_pkg::REQ_FREE, 0, 1);    // merges everything back
   endtask

   // Oversized init is capped to the whole store
   task automatic test_full_pool();
      send_request(ffha_pkg::REQ_INIT, 8191, 0);
      send_request(ffha_pkg::REQ_ALLOC, 4097, 0);
      send_request(ffha_pkg::REQ_ALLOC, 4096, 0);
      send_request(ffha_pkg::REQ_ALLOC, 4080, 0);
      send_request(ffha_pkg::REQ_FREE, 0, 1023);
      send_request(ffha_pkg::REQ_FREE, 0, 1);
   endtask

   // Random sessions: carve a pool, then mostly well-formed alloc/free
   // traffic with some junk frees and unknown kinds mixed in
   task automatic test_random_sessions();
      int pool_bytes, ops, pick, nbytes;
      while (beats_sent < WORK_ITEMS) begin
         case ($urandom_range(3, 0))
            0:       begin req_pace = 1'b0; rsp_pace = 1'b0; end
            1:       begin req_pace = 1'b1; rsp_pace = 1'b1; end
            2:       begin req_pace = 1'b1; rsp_pace = 1'b0; end
            default: begin req_pace = 1'b0; rsp_pace = 1'b1; end
         endcase
         pick = $urandom_range(19, 0);
         if (pick == 0)
            pool_bytes = $urandom_range(11, 0);
         else if (pick == 1)
            pool_bytes = $urandom_range(8191, 3000);
         else
            pool_bytes = $urandom_range(400, 12);
         send_request(ffha_pkg::REQ_INIT, pool_bytes, $urandom_range(1023, 0));
         ops = $urandom_range(60, 20);
         repeat (ops) begin
            pick = $urandom_range(99, 0);
            if (pick < 50 || (pick < 80 && live_blocks.size() == 0)) begin
               pick = $urandom_range(9, 0);
               if (pick < 7)
                  nbytes = $urandom_range(pool_bytes / 4, 0);
               else if (pick < 9)
                  nbytes = $urandom_range(16, 0);
               else
                  nbytes = $urandom_range(8191, 0);
               send_request(ffha_pkg::REQ_ALLOC, nbytes, $urandom_range(1023, 0));
            end else if (pick < 80) begin
               send_request(ffha_pkg::REQ_FREE, $urandom_range(8191, 0),
                            live_blocks[$urandom_range(live_blocks.size() - 1, 0)]);
            end else if (pick < 94) begin
               send_request(ffha_pkg::REQ_FREE, $urandom_range(8191, 0),
                            $urandom_range(1023, 0));
            end else begin
               send_request(REQ_UNUSED, $urandom_range(8191, 0), $urandom_range(1023, 0));
            end
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_before_init();
      test_tiny_pool();
      test_fit_rules();
      test_full_pool();
      test_random_sessions();

      // Hold the request channel idle and drain the outstanding replies
      req_tvalid <= 1'b0;
      while (expected_replies.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d requests over %0d pool inits: %0d blocks granted, %0d freed,",
               beats_sent, pools_carved, allocs_done, frees_done);
      $display("%0d refused or ignored; %0d replies checked, %0d mismatches",
               refusals, replies_seen, error_count);
      if (error_count == 0)
         $display("first_fit_heap_allocator_top_tb: done, clean");
      else
         $display("first_fit_heap_allocator_top_tb: done, errors");
      $finish;
   end

endmodule

// File: first_fit_heap_allocator_top.f
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_datapath.sv
hw/rtl/ffha_ctrl.sv
hw/rtl/first_fit_heap_allocator_top.sv
test/first_fit_heap_allocator_top_tb.sv
